[rtl/core/mdfs_pkg.sv]
`timescale 1ns / 1ps
// mdfs_pkg: stage and result-kind types, marker text and marker lookup functions
// for the marker delimited field splitter; no dependencies

package mdfs_pkg;

   // record parsing stages
   typedef enum logic [2:0] {
      ST_SEEK   = 3'd0,
      ST_TITLE  = 3'd1,
      ST_AUTHOR = 3'd2,
      ST_AD     = 3'd3,
      ST_LINK   = 3'd4,
      ST_DONE   = 3'd5
   } stage_type;

   // result kinds
   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_CLOSE   = 2'd1,
      KIND_DONE    = 2'd2
   } kind_type;

   localparam int unsigned MARK_MAX_LEN = 10;
   localparam int unsigned MARK_BITS    = 8 * MARK_MAX_LEN;

   // marker text, last character in the low byte, zero padded at the top
   localparam logic [MARK_BITS-1:0] MARK_TITLE  = "*$TITLE%*";
   localparam logic [MARK_BITS-1:0] MARK_AUTHOR = "*$AUTHOR%*";
   localparam logic [MARK_BITS-1:0] MARK_AD     = "*$AD%*";
   localparam logic [MARK_BITS-1:0] MARK_LINK   = "*$LINK%*";
   localparam logic [MARK_BITS-1:0] MARK_END    = "*$END%*";

   // closing marker of a stage
   function automatic logic [MARK_BITS-1:0] marker_bits(stage_type s);
      case (s)
         ST_SEEK:   marker_bits = MARK_TITLE;
         ST_TITLE:  marker_bits = MARK_AUTHOR;
         ST_AD:     marker_bits = MARK_LINK;
         ST_AUTHOR: marker_bits = MARK_AD;
         default:   marker_bits = MARK_END;
      endcase
   endfunction

   // length of that marker
   function automatic logic [3:0] marker_len(stage_type s);
      case (s)
         ST_SEEK:   marker_len = 4'd9;
         ST_TITLE:  marker_len = 4'd10;
         ST_AUTHOR: marker_len = 4'd6;
         ST_AD:     marker_len = 4'd8;
         default:   marker_len = 4'd7;
      endcase
   endfunction

endpackage

[rtl/core/mdfs_stream_if.sv]
`timescale 1ns / 1ps
// mdfs_req_if and mdfs_rsp_if: valid/ready channels of the field splitter
// no dependencies

interface mdfs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface mdfs_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [1:0] field_id;
   logic [7:0] out_byte;

   modport source (output valid, output kind, output field_id, output out_byte, input ready);
   modport sink   (input valid, input kind, input field_id, input out_byte, output ready);
endinterface

[rtl/core/marker_delimited_field_splitter.sv]
`timescale 1ns / 1ps
// marker_delimited_field_splitter: top level of the marker framed record splitter
// depends on mdfs_pkg and the channel interfaces in mdfs_stream_if.sv
//
// usage
//   req carries one raw byte per transfer (in_byte). rsp carries at most one
//   result per input byte: a payload byte of the open field, a field-closed
//   mark, or a record-complete mark (kind, field_id, out_byte).
//   bytes are dropped until *$TITLE%*; then title, author, ad and link are
//   routed out in turn, closed by *$AUTHOR%*, *$AD%*, *$LINK%*, *$END%*.
//   the byte after *$END%* yields the record-complete mark and is dropped.
//   bytes are held back by one less than the closing marker length, so no
//   marker text ever shows up as payload.
// timing
//   one transfer per cycle on both sides while rsp is not stalled. a byte is
//   held in the input register, is compared against the stage's marker and
//   the held history, and its result lands in the output register, which
//   drives rsp. the marker compare against the history shift register is
//   the combinational processing step between the two registers.
// reset and stalls
//   synchronous reset returns to seeking the title marker with nothing held.
//   while rsp is stalled the output register holds its result; one more byte
//   still waits in the input register, then req_ready drops.

module marker_delimited_field_splitter
   import mdfs_pkg::*;
#(
   parameter int unsigned HISTORY_DEPTH = 9
) (
   input  logic             clock,
   input  logic             reset,
   mdfs_req_if.sink         req,
   mdfs_rsp_if.source       rsp
);

   localparam int unsigned HIST_IDX_W = $clog2(HISTORY_DEPTH);

   // input register
   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff;

   // parser state
   stage_type             stage_ff, stage_in;
   logic [3:0]            held_count_ff, held_count_in;
   logic [7:0]            history_ff [HISTORY_DEPTH];

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   kind_type              rsp_kind_ff, rsp_kind_in;
   logic [1:0]            rsp_field_ff, rsp_field_in;
   logic [7:0]            rsp_byte_ff, rsp_byte_in;

   // processing step
   logic                  out_free;      // result register can take a new result
   logic                  step;          // byte in the input register is processed now
   logic                  push;
   logic [MARK_BITS-1:0]  mark;
   logic [3:0]            hold;
   logic                  held_full;
   logic                  suffix_ok;
   logic                  hit;
   logic [7:0]            released;
   logic [2:0]            field_wide;
   logic                  emit;
   kind_type              kind_c;
   logic [1:0]            field_c;
   logic [7:0]            byte_c;

   // handshakes
   assign out_free    = !rsp_valid_ff || rsp.ready;
   assign step        = in_valid_ff && out_free;
   assign req.ready   = !in_valid_ff || out_free;
   assign in_valid_in = req.ready ? req.valid : in_valid_ff;

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.kind     = rsp_kind_ff;
   assign rsp.field_id = rsp_field_ff;
   assign rsp.out_byte = rsp_byte_ff;

   // marker compare: current byte is the marker's last char, history the rest
   always_comb begin
      mark      = marker_bits(stage_ff);
      hold      = marker_len(stage_ff) - 4'd1;
      held_full = (held_count_ff >= hold);
      suffix_ok = (in_byte_ff == mark[7:0]);
      for (int k = 1; k < MARK_MAX_LEN; k++) begin
         if (4'(k) <= hold) begin
            suffix_ok = suffix_ok && (history_ff[HIST_IDX_W'(k - 1)] == mark[8*k +: 8]);
         end
      end
      hit        = held_full && suffix_ok;
      released   = history_ff[HIST_IDX_W'(hold - 4'd1)];
      field_wide = stage_ff - 3'd1;
   end

   // next state
   always_comb begin
      stage_in      = stage_ff;
      held_count_in = held_count_ff;
      push          = 1'b0;
      if (step) begin
         case (stage_ff)
            ST_SEEK, ST_TITLE, ST_AUTHOR, ST_AD, ST_LINK: begin
               if (hit) begin
                  stage_in      = stage_type'(stage_ff + 3'd1);
                  held_count_in = 4'd0;
               end else begin
                  push = 1'b1;
                  if (!held_full) begin
                     held_count_in = held_count_ff + 4'd1;
                  end
               end
            end
            default: begin
               // byte after the end marker closes the record
               stage_in      = ST_SEEK;
               held_count_in = 4'd0;
            end
         endcase
      end
   end

   // result of the processed byte
   always_comb begin
      emit    = 1'b0;
      kind_c  = KIND_PAYLOAD;
      field_c = field_wide[1:0];
      byte_c  = 8'd0;
      case (stage_ff)
         ST_SEEK: begin
            emit = 1'b0;
         end
         ST_TITLE, ST_AUTHOR, ST_AD, ST_LINK: begin
            if (hit) begin
               emit   = 1'b1;
               kind_c = KIND_CLOSE;
            end else if (held_full) begin
               emit   = 1'b1;
               kind_c = KIND_PAYLOAD;
               byte_c = released;
            end
         end
         default: begin
            emit    = 1'b1;
            kind_c  = KIND_DONE;
            field_c = 2'd0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = step ? emit : (rsp_valid_ff && !rsp.ready);
      rsp_kind_in  = rsp_kind_ff;
      rsp_field_in = rsp_field_ff;
      rsp_byte_in  = rsp_byte_ff;
      if (step && emit) begin
         rsp_kind_in  = kind_c;
         rsp_field_in = field_c;
         rsp_byte_in  = byte_c;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         stage_ff      <= ST_SEEK;
         held_count_ff <= 4'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         stage_ff      <= stage_in;
         held_count_ff <= held_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req.ready) begin
         in_byte_ff <= req.in_byte;
      end
      rsp_kind_ff  <= rsp_kind_in;
      rsp_field_ff <= rsp_field_in;
      rsp_byte_ff  <= rsp_byte_in;
      // history is a shift line, newest byte first
      if (push) begin
         history_ff[0] <= in_byte_ff;
         for (int i = 1; i < HISTORY_DEPTH; i++) begin
            history_ff[i] <= history_ff[i-1];
         end
      end
   end

   // checks
   held_in_range: assert property (@(posedge clock) disable iff (reset)
      held_count_ff <= 4'd9)
      else $error("held byte count beyond longest marker prefix");

   done_waits_in_seek: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_DONE) |-> (stage_ff == ST_SEEK))
      else $error("parser left seek stage while record-complete result pending");

   payload_in_field: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_PAYLOAD) |->
         (stage_ff != ST_SEEK && stage_ff != ST_DONE))
      else $error("payload result outside an open field");

   marks_carry_no_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff != KIND_PAYLOAD) |-> (rsp_byte_ff == 8'd0))
      else $error("close or complete result carries a data byte");

   hit_clears_hold: assert property (@(posedge clock) disable iff (reset)
      (step && hit && stage_ff != ST_DONE) |=> (held_count_ff == 4'd0))
      else $error("held bytes survive a marker match");

endmodule
